/* hw/rtl/vn_pkg.sv */
// vn_pkg: types, constants and controller codes for vector_normalize_q16.
// Used by vn_ctrl, vn_dpath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vn_pkg;

  localparam int CompW     = 32;
  localparam int LenShift  = 8;
  localparam int FracShift = 16;
  localparam int LenW      = 16;
  localparam int NumComp   = 3;
  localparam int SqrtSteps = 16;
  localparam int DivSteps  = CompW;
  localparam int CntW      = 5;

  typedef struct packed {
    logic signed [CompW-1:0] in_x;
    logic signed [CompW-1:0] in_y;
    logic signed [CompW-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [CompW-1:0] out_x;
    logic signed [CompW-1:0] out_y;
    logic signed [CompW-1:0] out_z;
    logic                    passed_through;
  } out_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SQUARE  = 7'b0000010,
    ST_CHECK   = 7'b0000100,
    ST_SQRT    = 7'b0001000,
    ST_DIVINIT = 7'b0010000,
    ST_DIVIDE  = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic       load;
    logic       sq_mul;
    logic       sq_acc;
    logic [1:0] sq_idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic sum_bad;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/vn_ctrl.sv */
// vn_ctrl: sequencing state machine for vector_normalize_q16.
// Issues cmd_t to vn_dpath and reads status_t back; depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vn_ctrl import vn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sq_idx = cnt_q[1:0];
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        cnt_d      = '0;
        if (accept) state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.sq_mul = (cnt_q != CntW'(NumComp));
        cmd_o.sq_acc = (cnt_q != '0);
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumComp)) begin
          cnt_d   = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = status_i.sum_bad ? ST_FINISH : ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_DIVINIT;
        end
      end
      ST_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vn_dpath.sv */
// vn_dpath: squares, bit-serial square root, three divider lanes, output reg.
// Driven by cmd_t from vn_ctrl, reports status_t; depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vn_dpath import vn_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_i,
  input  wire cmd_t cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

  in_t                     vec_q;
  logic [CompW-1:0]        comp [NumComp];
  logic signed [CompW-1:0] sq_sel;
  logic signed [2*CompW-1:0] sq_full;
  logic [CompW-1:0]        prod_q, sum_q;

  logic [CompW-1:0]        root_q, rem_q, bit_q, root_bit;

  logic [LenW-1:0]         div_q;
  logic [CompW-1:0]        quo_q [NumComp];
  logic [LenW-1:0]         drem_q [NumComp];
  logic                    neg_q [NumComp];
  logic [CompW-1:0]        sh [NumComp];
  logic [LenW:0]           trial [NumComp];
  logic                    take [NumComp];
  logic [CompW-1:0]        res [NumComp];

  logic                    out_valid_q;
  out_t                    out_q;

  assign comp[0] = vec_q.in_x;
  assign comp[1] = vec_q.in_y;
  assign comp[2] = vec_q.in_z;

  always_comb begin
    case (cmd_i.sq_idx)
      2'd0:    sq_sel = vec_q.in_x;
      2'd1:    sq_sel = vec_q.in_y;
      2'd2:    sq_sel = vec_q.in_z;
      default: sq_sel = vec_q.in_x;
    endcase
  end

  assign sq_full = sq_sel * sq_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) vec_q <= in_i;
    if (cmd_i.sq_mul) prod_q <= sq_full[FracShift +: CompW];
    if (cmd_i.load) sum_q <= '0;
    else if (cmd_i.sq_acc) sum_q <= sum_q + prod_q;
  end

  assign status_o.sum_bad  = (sum_q == '0) || sum_q[CompW-1];
  assign status_o.out_busy = out_valid_q && out_stall_i;

  // bit-serial floor square root
  assign root_bit = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rem_q  <= sum_q;
      root_q <= '0;
      bit_q  <= CompW'(1) << (CompW - 2);
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= root_bit) begin
        rem_q  <= rem_q - root_bit;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // three restoring divider lanes sharing one divisor
  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      sh[i]    = comp[i] << LenShift;
      trial[i] = {drem_q[i], quo_q[i][CompW-1]};
      take[i]  = (trial[i] >= {1'b0, div_q});
      res[i]   = neg_q[i] ? (~quo_q[i] + 1'b1) : quo_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      div_q <= root_q[LenW-1:0];
      for (int i = 0; i < NumComp; i++) begin
        neg_q[i]  <= sh[i][CompW-1];
        quo_q[i]  <= sh[i][CompW-1] ? (~sh[i] + 1'b1) : sh[i];
        drem_q[i] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < NumComp; i++) begin
        quo_q[i]  <= {quo_q[i][CompW-2:0], take[i]};
        drem_q[i] <= take[i] ? LenW'(trial[i] - {1'b0, div_q}) : trial[i][LenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (status_o.sum_bad) begin
        out_q.out_x <= vec_q.in_x;
        out_q.out_y <= vec_q.in_y;
        out_q.out_z <= vec_q.in_z;
        out_q.passed_through <= 1'b1;
      end else begin
        out_q.out_x <= res[0];
        out_q.out_y <= res[1];
        out_q.out_z <= res[2];
        out_q.passed_through <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* hw/rtl/vector_normalize_q16.sv */
// vector_normalize_q16: top level, normalizes a signed 16.16 3D vector.
// Instantiates vn_ctrl and vn_dpath; depends on vn_pkg.
//
//   channel | signals                        | payload
//   in      | in_valid_i, in_stall_o, in_i   | in_t  (in_x, in_y, in_z)
//   out     | out_valid_o, out_stall_i, out_o | out_t (out_x/y/z, passed_through)
//
// One item at a time: a normal vector runs 4 square/accumulate steps, 16
// square-root steps and 32 divide steps in three lanes; a passed-through item
// goes from the check straight to the final state. A new item is taken once the
// previous one sits in the output register. Reset clears the controller and the
// output valid; a stalled output holds the sequencer in its final state.
`timescale 1ns / 1ps
`default_nettype none

module vector_normalize_q16 import vn_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

  cmd_t    cmd;
  status_t status;

  vn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vn_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* dv/tb_vector_normalize_q16.sv */
// tb_vector_normalize_q16: self-checking testbench for vector_normalize_q16.
// Drives directed and random 16.16 vectors with random idling on both channels and
// checks each result against an in-bench predictor; depends on vn_pkg and the RTL.
`timescale 1ns / 1ps

module tb_vector_normalize_q16;
  import vn_pkg::*;

  class vec_scoreboard;
    out_t        norm_q[$];
    int unsigned fails;

    function logic [31:0] square_q16(logic signed [31:0] c);
      logic signed [63:0] p;
      p = 64'(c) * 64'(c);
      return p[47:16];
    endfunction

    function logic [31:0] scale_by_len(logic [31:0] raw, logic [15:0] len);
      logic signed [31:0] sh;
      logic signed [63:0] q;
      sh = raw << LenShift;
      q  = 64'(sh) / $signed({48'b0, len});
      return q[31:0];
    endfunction

    function out_t normalized_vec(in_t v);
      out_t        r;
      logic [31:0] sum;
      logic [15:0] len;
      longint      cand;
      sum = square_q16(v.in_x) + square_q16(v.in_y) + square_q16(v.in_z);
      if (sum == 0 || sum[31]) begin
        r.out_x = v.in_x;
        r.out_y = v.in_y;
        r.out_z = v.in_z;
        r.passed_through = 1'b1;
        return r;
      end
      // floor square root, one bit of the root per step from the top
      len = '0;
      for (int b = 15; b >= 0; b--) begin
        cand = longint'(len) | (longint'(1) << b);
        if (cand * cand <= longint'(sum)) len = cand[15:0];
      end
      r.out_x = scale_by_len(v.in_x, len);
      r.out_y = scale_by_len(v.in_y, len);
      r.out_z = scale_by_len(v.in_z, len);
      r.passed_through = 1'b0;
      return r;
    endfunction

    function void note_vector(in_t v);
      norm_q.push_back(normalized_vec(v));
    endfunction

    function void check_vector(out_t got);
      out_t want;
      bit   bad;
      if (norm_q.size() == 0) begin
        $error("result with no item pending: %h", got);
        fails++;
        return;
      end
      want = norm_q.pop_front();
      bad  = 1'b0;
      if (got.out_x !== want.out_x) begin
        $error("out_x expected %h actual %h", want.out_x, got.out_x);
        bad = 1'b1;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y expected %h actual %h", want.out_y, got.out_y);
        bad = 1'b1;
      end
      if (got.out_z !== want.out_z) begin
        $error("out_z expected %h actual %h", want.out_z, got.out_z);
        bad = 1'b1;
      end
      if (got.passed_through !== want.passed_through) begin
        $error("passed_through expected %b actual %b", want.passed_through,
               got.passed_through);
        bad = 1'b1;
      end
      if (bad) fails++;
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  in_t  in_data   = '0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  vec_scoreboard sb = new();

  vector_normalize_q16 dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_vector(out_data);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_vector(v);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_comp();
    logic [31:0] mask;
    logic [31:0] r;
    case ($urandom_range(0, 3))
      0: r = $urandom;
      1, 2: begin
        mask = (32'h1 << $urandom_range(1, 24)) - 1;
        r    = $urandom & mask;
        if ($urandom_range(0, 1) == 1) r = -r;
      end
      default: begin
        case ($urandom_range(0, 6))
          0: r = 32'h0000_0000;
          1: r = 32'h0000_0001;
          2: r = 32'hFFFF_FFFF;
          3: r = 32'h7FFF_FFFF;
          4: r = 32'h8000_0000;
          5: r = 32'h0001_0000;
          default: r = 32'hFFFF_0000;
        endcase
      end
    endcase
    return r;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vec(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000);
    send_vec(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_vec(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_vec(32'h0000_0100, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'hFFFF_FF00, 32'h0000_0100, 32'h0000_0000);
    send_vec(32'h00B6_0000, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h0080_0001, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'hFF7F_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h00B5_0000, 32'h0001_0000, 32'h0000_0000);
    send_vec(32'h0100_0000, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h0003_0000, 32'h0004_0000, 32'h0000_0000);
    send_vec(32'hFFFD_0000, 32'hFFFC_0000, 32'h000C_0000);
    send_vec(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    send_vec(32'h00B5_0000, 32'h00B5_0000, 32'h0000_0000);
    send_vec(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);

    for (int i = 0; i < 800; i++) begin
      if (i == 400) begin
        in_valid <= 1'b0;
        while (sb.norm_q.size() != 0) @(posedge clk);
      end
      if (i == 700) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      send_vec(rand_comp(), rand_comp(), rand_comp());
    end
    in_valid <= 1'b0;

    while (sb.norm_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.fails == 0) begin
      $display("vector_normalize_q16: match");
    end else begin
      $display("vector_normalize_q16: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("vector_normalize_q16: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/vn_pkg.sv
hw/rtl/vn_ctrl.sv
hw/rtl/vn_dpath.sv
hw/rtl/vector_normalize_q16.sv
dv/tb_vector_normalize_q16.sv
